@@ hw/rtl/tpcc_pkg.sv @@
// shared types, codes and helper functions for the two-player countdown clock
package tpcc_pkg;

	// configuration port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned TPS_W = 10;
	localparam logic [TPS_W-1:0] TPS_RESET = 10'd200;
	localparam logic REG_TPS = 1'b0;

	// field widths
	localparam int unsigned KEYS_W = 16;
	localparam int unsigned TIME_W = 14;

	// keypad bit positions
	localparam int unsigned KEY_START = 0;
	localparam int unsigned KEY_ONE = 3;
	localparam int unsigned KEY_TWO = 7;
	localparam int unsigned KEY_THREE = 11;
	localparam int unsigned KEY_FOUR = 2;

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEYS = 1'b1;

	typedef enum logic [1:0] {
		PH_SETTING = 2'd0,
		PH_RUNNING = 2'd1,
		PH_FINISHED = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_WHITE = 2'd1,
		TURN_BLACK = 2'd2
	} turn_t;

	typedef enum logic [1:0] {
		WIN_NONE = 2'd0,
		WIN_BLACK = 2'd1,
		WIN_WHITE = 2'd2
	} winner_t;

	// time held as decimal digits mm:ss, second tens never above 6 when stored
	typedef struct packed {
		logic [3:0] mt;
		logic [3:0] mu;
		logic [2:0] st;
		logic [3:0] su;
	} mmss_t;

	typedef struct packed {
		logic opcode;
		logic [KEYS_W-1:0] keys;
	} item_t;

	typedef struct packed {
		phase_t phase;
		turn_t turn;
		logic [TIME_W-1:0] setup_time;
		logic [TIME_W-1:0] white_left;
		logic [TIME_W-1:0] black_left;
		winner_t winner;
		logic timeout_pulse;
	} result_t;

	// decimal MMSS value of a digit set
	function automatic logic [TIME_W-1:0] mmss_value(input mmss_t v);
		mmss_value = TIME_W'(v.mt) * 14'd1000 + TIME_W'(v.mu) * 14'd100
			+ TIME_W'(v.st) * 14'd10 + TIME_W'(v.su);
	endfunction

	// one second off, saturating at zero, seconds skip from 00 to 59
	function automatic mmss_t mmss_dec(input mmss_t v);
		mmss_t r;
		logic b0;
		logic b1;
		logic b2;
		b0 = (v.su == 4'd0);
		b1 = b0 && (v.st == 3'd0);
		b2 = b1 && (v.mu == 4'd0);
		r.su = b0 ? 4'd9 : v.su - 4'd1;
		r.st = b0 ? ((v.st == 3'd0) ? 3'd5 : v.st - 3'd1) : v.st;
		r.mu = b1 ? ((v.mu == 4'd0) ? 4'd9 : v.mu - 4'd1) : v.mu;
		r.mt = b2 ? v.mt - 4'd1 : v.mt;
		if (v == '0) begin
			r = v;
		end
		mmss_dec = r;
	endfunction

endpackage

@@ hw/rtl/tpcc_cfg.sv @@
// apb register block holding the ticks-per-second setting
module tpcc_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tpcc_pkg::PADDR_W-1:0] paddr,
	input  logic [tpcc_pkg::PDATA_W-1:0] pwdata,
	output logic [tpcc_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output logic [tpcc_pkg::TPS_W-1:0] tps
);

	logic [tpcc_pkg::TPS_W-1:0] tps_q;
	logic hit;

	// word decode, byte offset bits ignored
	assign hit = (paddr[2] == tpcc_pkg::REG_TPS);

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= tpcc_pkg::TPS_RESET;
		end else if (psel && penable && pwrite && hit) begin
			tps_q <= pwdata[tpcc_pkg::TPS_W-1:0];
		end
	end

	// read back
	assign prdata = hit ? tpcc_pkg::PDATA_W'(tps_q) : '0;
	assign pready = 1'b1;
	assign tps = tps_q;

endmodule

@@ hw/rtl/tpcc_core.sv @@
// game state, single-pass update and result register
module tpcc_core (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  tpcc_pkg::item_t item_s1,
	input  logic [tpcc_pkg::TPS_W-1:0] tps,
	input  logic result_ready,
	output logic take,
	output logic result_valid,
	output tpcc_pkg::result_t result
);

	tpcc_pkg::phase_t phase_q, phase_n;
	tpcc_pkg::turn_t turn_q, turn_n;
	tpcc_pkg::winner_t win_q, win_n;
	tpcc_pkg::mmss_t dig_q, dig_n;
	tpcc_pkg::mmss_t wcnt_q, wcnt_n;
	tpcc_pkg::mmss_t bcnt_q, bcnt_n;
	logic [tpcc_pkg::TPS_W-1:0] wpre_q, wpre_n;
	logic [tpcc_pkg::TPS_W-1:0] bpre_q, bpre_n;
	logic [tpcc_pkg::KEYS_W-1:0] prev_q, prev_n;
	logic pulse;
	logic fire;
	logic sel_white;
	logic [tpcc_pkg::TPS_W-1:0] pre_sel;
	logic [tpcc_pkg::TPS_W:0] pre_inc;
	logic complete;
	tpcc_pkg::mmss_t cnt_sel, cnt_dec;
	logic hit_zero;
	logic result_valid_q;
	tpcc_pkg::result_t result_q;

	// result slot free or being emptied
	assign take = !result_valid_q || result_ready;
	assign fire = valid_s1 && take;

	// shared prescaler increment and countdown step, applied to the running player's prescaler and count
	assign sel_white = (turn_q == tpcc_pkg::TURN_WHITE);
	assign pre_sel = sel_white ? wpre_q : bpre_q;
	assign cnt_sel = sel_white ? wcnt_q : bcnt_q;
	assign pre_inc = {1'b0, pre_sel} + 11'd1;
	assign complete = !(pre_inc < {1'b0, tps});
	assign cnt_dec = tpcc_pkg::mmss_dec(cnt_sel);
	assign hit_zero = (cnt_dec == '0);

	// next state for one transaction
	always_comb begin
		phase_n = phase_q;
		turn_n = turn_q;
		win_n = win_q;
		dig_n = dig_q;
		wcnt_n = wcnt_q;
		bcnt_n = bcnt_q;
		wpre_n = wpre_q;
		bpre_n = bpre_q;
		prev_n = prev_q;
		pulse = 1'b0;
		if (fire) begin
			if (item_s1.opcode == tpcc_pkg::OP_TICK) begin
				if (phase_q == tpcc_pkg::PH_RUNNING &&
					(turn_q == tpcc_pkg::TURN_WHITE || turn_q == tpcc_pkg::TURN_BLACK)) begin
					if (!complete) begin
						if (sel_white) begin
							wpre_n = pre_inc[tpcc_pkg::TPS_W-1:0];
						end else begin
							bpre_n = pre_inc[tpcc_pkg::TPS_W-1:0];
						end
					end else begin
						if (sel_white) begin
							wpre_n = '0;
							wcnt_n = cnt_dec;
						end else begin
							bpre_n = '0;
							bcnt_n = cnt_dec;
						end
						if (hit_zero) begin
							pulse = 1'b1;
							phase_n = tpcc_pkg::PH_FINISHED;
							turn_n = tpcc_pkg::TURN_NONE;
							win_n = sel_white ? tpcc_pkg::WIN_BLACK : tpcc_pkg::WIN_WHITE;
						end
					end
				end
			end else if (item_s1.keys != prev_q) begin
				prev_n = item_s1.keys;
				unique case (phase_q)
					tpcc_pkg::PH_SETTING: begin
						// digits step first, start then loads them
						if (item_s1.keys[tpcc_pkg::KEY_ONE]) begin
							dig_n.mt = (dig_q.mt >= 4'd9) ? 4'd0 : dig_q.mt + 4'd1;
						end
						if (item_s1.keys[tpcc_pkg::KEY_TWO]) begin
							dig_n.mu = (dig_q.mu >= 4'd9) ? 4'd0 : dig_q.mu + 4'd1;
						end
						if (item_s1.keys[tpcc_pkg::KEY_THREE]) begin
							dig_n.st = (dig_q.st >= 3'd6) ? 3'd0 : dig_q.st + 3'd1;
						end
						if (item_s1.keys[tpcc_pkg::KEY_FOUR]) begin
							dig_n.su = (dig_q.su >= 4'd9) ? 4'd0 : dig_q.su + 4'd1;
						end
						if (item_s1.keys[tpcc_pkg::KEY_START]) begin
							wcnt_n = dig_n;
							bcnt_n = dig_n;
							wpre_n = '0;
							bpre_n = '0;
							phase_n = tpcc_pkg::PH_RUNNING;
							turn_n = tpcc_pkg::TURN_WHITE;
						end
					end
					tpcc_pkg::PH_RUNNING: begin
						// black wins when both keys are down
						if (item_s1.keys[tpcc_pkg::KEY_ONE]) begin
							turn_n = tpcc_pkg::TURN_WHITE;
						end
						if (item_s1.keys[tpcc_pkg::KEY_TWO]) begin
							turn_n = tpcc_pkg::TURN_BLACK;
						end
					end
					tpcc_pkg::PH_FINISHED: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tpcc_pkg::PH_SETTING;
			turn_q <= tpcc_pkg::TURN_NONE;
			win_q <= tpcc_pkg::WIN_NONE;
			dig_q <= '0;
			wcnt_q <= '0;
			bcnt_q <= '0;
			wpre_q <= '0;
			bpre_q <= '0;
			prev_q <= '0;
		end else begin
			phase_q <= phase_n;
			turn_q <= turn_n;
			win_q <= win_n;
			dig_q <= dig_n;
			wcnt_q <= wcnt_n;
			bcnt_q <= bcnt_n;
			wpre_q <= wpre_n;
			bpre_q <= bpre_n;
			prev_q <= prev_n;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.phase <= phase_n;
			result_q.turn <= turn_n;
			result_q.setup_time <= tpcc_pkg::mmss_value(dig_n);
			result_q.white_left <= tpcc_pkg::mmss_value(wcnt_n);
			result_q.black_left <= tpcc_pkg::mmss_value(bcnt_n);
			result_q.winner <= win_n;
			result_q.timeout_pulse <= pulse;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

@@ hw/rtl/two_player_countdown_clock.sv @@
// top level of the two-player countdown chess clock
//
// item channel: item_valid/item_ready carry opcode (0 tick, 1 keypad bitmap) and
// keys. result channel: result_valid/result_ready carry phase, turn, setup_time,
// white_left, black_left, winner and timeout_pulse, one result per item.
// ticks_per_second is written over the apb port at byte address 0; the user must
// write it only while the block is idle, which the block itself does not enforce.
// an accepted item sits in the input register until the result slot is free; it
// then updates the game state and the result register together, and its result
// is offered from then on.
// throughput: one item per cycle while results are taken; the whole update is one
// pass of logic between the input register and the result register.
// reset puts the clock in the setting phase with all digits, counts and
// prescalers at zero and ticks_per_second at 200.
// when the receiver stalls, the result register holds, the input register
// takes one more item, and then item_ready falls until the result is taken.
module two_player_countdown_clock (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tpcc_pkg::PADDR_W-1:0] paddr,
	input  logic [tpcc_pkg::PDATA_W-1:0] pwdata,
	output logic [tpcc_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input  logic item_valid,
	output logic item_ready,
	input  logic opcode,
	input  logic [tpcc_pkg::KEYS_W-1:0] keys,
	output logic result_valid,
	input  logic result_ready,
	output logic [1:0] phase,
	output logic [1:0] turn,
	output logic [tpcc_pkg::TIME_W-1:0] setup_time,
	output logic [tpcc_pkg::TIME_W-1:0] white_left,
	output logic [tpcc_pkg::TIME_W-1:0] black_left,
	output logic [1:0] winner,
	output logic timeout_pulse
);

	logic [tpcc_pkg::TPS_W-1:0] tps;
	logic valid_s1;
	tpcc_pkg::item_t item_s1;
	logic take;
	tpcc_pkg::result_t result;

	tpcc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.tps    (tps)
	);

	// input register
	assign item_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.opcode <= opcode;
			item_s1.keys <= keys;
		end
	end

	tpcc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.tps         (tps),
		.result_ready(result_ready),
		.take        (take),
		.result_valid(result_valid),
		.result      (result)
	);

	// result fields
	assign phase = result.phase;
	assign turn = result.turn;
	assign setup_time = result.setup_time;
	assign white_left = result.white_left;
	assign black_left = result.black_left;
	assign winner = result.winner;
	assign timeout_pulse = result.timeout_pulse;

endmodule

@@ hw/rtl/tpcc_checker.sv @@
// port-level checks for the two-player countdown clock, bound to the top level
module tpcc_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input logic [1:0] phase,
	input logic [1:0] turn,
	input logic [1:0] winner,
	input logic timeout_pulse
);

	logic seen_finished_q;

	// remembers that a finished result has been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_finished_q <= 1'b0;
		end else if (result_valid && result_ready && phase == tpcc_pkg::PH_FINISHED) begin
			seen_finished_q <= 1'b1;
		end
	end

	// a stalled result stays valid and keeps its phase, turn, winner and timeout_pulse
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(phase) && $stable(turn)
			&& $stable(winner) && $stable(timeout_pulse))
	else $error("stalled result changed");

	// a timeout ends the game with a winner and no running clock
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && timeout_pulse |-> phase == tpcc_pkg::PH_FINISHED
			&& turn == tpcc_pkg::TURN_NONE && winner != tpcc_pkg::WIN_NONE)
	else $error("timeout without finished game");

	// a winner exists exactly when the game is finished, and no clock is running exactly when the game is not running
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((winner != tpcc_pkg::WIN_NONE) == (phase == tpcc_pkg::PH_FINISHED))
			&& ((turn == tpcc_pkg::TURN_NONE) == (phase != tpcc_pkg::PH_RUNNING)))
	else $error("winner, turn and phase disagree");

	// finished holds until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_finished_q |-> phase == tpcc_pkg::PH_FINISHED
			&& !timeout_pulse)
	else $error("game left the finished phase");

endmodule

bind two_player_countdown_clock tpcc_checker u_tpcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.phase        (phase),
	.turn         (turn),
	.winner       (winner),
	.timeout_pulse(timeout_pulse)
);
